// ===== rtl/core/hid_boot_report_decoder_macros.svh =====
// Shared assertion macros for the HID boot report decoder
`ifndef HID_BOOT_REPORT_DECODER_MACROS_SVH
`define HID_BOOT_REPORT_DECODER_MACROS_SVH

// expression holds at every edge outside reset
`define HBRD_ASSERT_HOLDS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define HBRD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/hbrd_pkg.sv =====
package hbrd_pkg;

    // item kinds carried on tuser
    localparam logic [2:0] KIND_REPORT   = 3'd0;
    localparam logic [2:0] KIND_POP_KEY  = 3'd1;
    localparam logic [2:0] KIND_READ_AX  = 3'd2;
    localparam logic [2:0] KIND_READ_BTN = 3'd3;
    localparam logic [2:0] KIND_SET_LEDS = 3'd4;

    // device kinds in the config register
    localparam logic [1:0] DEV_KEYBOARD = 2'd1;
    localparam logic [1:0] DEV_MOUSE    = 2'd2;

    localparam int DEF_MAX_KEYS    = 6;
    localparam int DEF_MAX_BUTTONS = 8;
    localparam int AXIS_SLOTS      = 3;
    localparam int POS_W           = 4;
    localparam logic [POS_W-1:0] POS_LIMIT = 4'd8;
    localparam int QUEUE_DEPTH     = 2;

    // classified beat handed from front to back
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] byte_val;
        logic [2:0] item_idx;
        logic       pos0;
        logic       pos1;
        logic       pos2;
        logic       pos3;
        logic       key_slot;   // positions 2 to 7
    } op_t;

    // queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic not_empty;
    } q_stat_t;

endpackage

// ===== rtl/core/hbrd_front.sv =====
module hbrd_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [15:0]     s_tdata,    // byte_value[7:0], item_index[10:8], zeros
    input  logic [2:0]      s_tuser,    // kind
    input  logic            s_tlast,    // last_byte
    input  hbrd_pkg::q_stat_t q_stat,
    output logic            push,
    output hbrd_pkg::op_t   push_op
);
    import hbrd_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;

    // byte position: advances on report beats, saturates, cleared by tlast on a report beat
    always_comb begin
        pos_next = pos_reg;
        if (push && s_tuser == KIND_REPORT) begin
            if (s_tlast) begin
                pos_next = '0;
            end else if (pos_reg < POS_LIMIT) begin
                pos_next = pos_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    // classify the beat
    always_comb begin
        push_op.kind     = s_tuser;
        push_op.byte_val = s_tdata[7:0];
        push_op.item_idx = s_tdata[10:8];
        push_op.pos0     = (pos_reg == 4'd0);
        push_op.pos1     = (pos_reg == 4'd1);
        push_op.pos2     = (pos_reg == 4'd2);
        push_op.pos3     = (pos_reg == 4'd3);
        push_op.key_slot = (pos_reg >= 4'd2) && (pos_reg < POS_LIMIT);
    end

endmodule

// ===== rtl/core/hbrd_queue.sv =====
`include "hid_boot_report_decoder_macros.svh"

module hbrd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  hbrd_pkg::op_t     push_op,
    input  logic              pop,
    output hbrd_pkg::op_t     pop_op,
    output hbrd_pkg::q_stat_t q_stat
);
    import hbrd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign pop_op           = mem_reg[rd_ptr_reg];
    assign q_stat.full      = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign q_stat.not_empty = (cnt_reg != '0);

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

    `HBRD_ASSERT_HOLDS(a_q_no_underflow, aclk, aresetn, !pop || cnt_reg != '0,
        "queue popped while empty")
    `HBRD_ASSERT_HOLDS(a_q_no_overflow, aclk, aresetn, cnt_reg <= CNT_W'(QUEUE_DEPTH),
        "queue count above depth")
    `HBRD_ASSERT_NEXT(a_q_count_up, aclk, aresetn, push && !pop,
        cnt_reg == $past(cnt_reg) + 1'b1, "queue count did not follow push")

endmodule

// ===== rtl/core/hbrd_back.sv =====
`include "hid_boot_report_decoder_macros.svh"

module hbrd_back #(
    parameter int MAX_KEYS    = hbrd_pkg::DEF_MAX_KEYS,
    parameter int MAX_BUTTONS = hbrd_pkg::DEF_MAX_BUTTONS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_wdata,
    input  hbrd_pkg::q_stat_t q_stat,
    input  hbrd_pkg::op_t     pop_op,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata
);
    import hbrd_pkg::*;

    localparam int KEY_IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int BTN_IDX_W = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;

    logic [1:0] dev_reg;
    logic [7:0] led_reg, led_next;
    logic [7:0] key_list_reg [MAX_KEYS];
    logic [7:0] key_list_next [MAX_KEYS];
    logic [2:0] key_total_reg, key_total_next;
    logic [3:0] btn_list_reg [MAX_BUTTONS];
    logic [3:0] btn_list_next [MAX_BUTTONS];
    logic [3:0] btn_total_reg, btn_total_next;
    logic [7:0] axis_list_reg [AXIS_SLOTS];
    logic [7:0] axis_list_next [AXIS_SLOTS];
    logic [1:0] axis_total_reg, axis_total_next;
    logic [7:0] held_x_reg, held_x_next;
    logic [8:0] read_val;
    logic       m_valid_reg;
    logic [31:0] m_data_reg;

    // take a beat when the output slot is free or being drained
    assign pop      = q_stat.not_empty && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // execute one op against the decoder state
    always_comb begin
        led_next        = led_reg;
        key_list_next   = key_list_reg;
        key_total_next  = key_total_reg;
        btn_list_next   = btn_list_reg;
        btn_total_next  = btn_total_reg;
        axis_list_next  = axis_list_reg;
        axis_total_next = axis_total_reg;
        held_x_next     = held_x_reg;
        read_val        = '0;
        unique case (pop_op.kind)
            KIND_REPORT: begin
                if (dev_reg == DEV_KEYBOARD) begin
                    if (pop_op.pos0) begin
                        led_next = {5'b0, pop_op.byte_val[0], pop_op.byte_val[2],
                                    pop_op.byte_val[1]};
                        key_total_next = '0;
                    end else if (pop_op.key_slot && pop_op.byte_val != 8'd0
                                 && key_total_reg < 3'(MAX_KEYS)) begin
                        key_list_next[key_total_reg[KEY_IDX_W-1:0]] = pop_op.byte_val;
                        key_total_next = key_total_reg + 3'd1;
                    end
                end else if (dev_reg == DEV_MOUSE) begin
                    if (pop_op.pos0) begin
                        // rank set bits into button numbers
                        btn_total_next = '0;
                        for (int b = 0; b < 8; b++) begin
                            if (pop_op.byte_val[b] && btn_total_next < 4'(MAX_BUTTONS)) begin
                                btn_list_next[btn_total_next[BTN_IDX_W-1:0]] = 4'(b + 1);
                                btn_total_next = btn_total_next + 4'd1;
                            end
                        end
                    end else if (pop_op.pos1) begin
                        held_x_next = pop_op.byte_val;
                    end else if (pop_op.pos2) begin
                        axis_list_next[0] = held_x_reg;
                        axis_list_next[1] = pop_op.byte_val;
                        axis_total_next   = 2'd2;
                    end else if (pop_op.pos3) begin
                        axis_list_next[2] = pop_op.byte_val;
                        axis_total_next   = 2'd3;
                    end
                end
            end
            KIND_POP_KEY: begin
                if (key_total_reg == 3'd0) begin
                    read_val = 9'h1FF;
                end else begin
                    read_val = {1'b0, key_list_reg[0]};
                    for (int i = 0; i < MAX_KEYS - 1; i++) begin
                        key_list_next[i] = key_list_reg[i + 1];
                    end
                    key_total_next = key_total_reg - 3'd1;
                end
            end
            KIND_READ_AX: begin
                if ({1'b0, pop_op.item_idx} < {2'b0, axis_total_reg}) begin
                    read_val = {axis_list_reg[pop_op.item_idx[1:0]][7],
                                axis_list_reg[pop_op.item_idx[1:0]]};
                end
            end
            KIND_READ_BTN: begin
                if ({1'b0, pop_op.item_idx} < btn_total_reg) begin
                    read_val = {5'b0, btn_list_reg[pop_op.item_idx[BTN_IDX_W-1:0]]};
                end
            end
            KIND_SET_LEDS: begin
                led_next = pop_op.byte_val;
            end
            default: begin
            end
        endcase
    end

    // config register and decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_reg        <= '0;
            led_reg        <= '0;
            key_total_reg  <= '0;
            btn_total_reg  <= '0;
            axis_total_reg <= '0;
            held_x_reg     <= '0;
            for (int i = 0; i < MAX_KEYS; i++) key_list_reg[i] <= '0;
            for (int i = 0; i < MAX_BUTTONS; i++) btn_list_reg[i] <= '0;
            for (int i = 0; i < AXIS_SLOTS; i++) axis_list_reg[i] <= '0;
        end else begin
            if (cfg_we) begin
                dev_reg <= cfg_wdata;
            end
            if (pop) begin
                led_reg        <= led_next;
                key_list_reg   <= key_list_next;
                key_total_reg  <= key_total_next;
                btn_list_reg   <= btn_list_next;
                btn_total_reg  <= btn_total_next;
                axis_list_reg  <= axis_list_next;
                axis_total_reg <= axis_total_next;
                held_x_reg     <= held_x_next;
            end
        end
    end

    // output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= {6'b0, axis_total_next, btn_total_next, key_total_next,
                           led_next, read_val};
        end
    end

    `HBRD_ASSERT_HOLDS(a_keys_bounded, aclk, aresetn, key_total_reg <= 3'(MAX_KEYS),
        "key count above limit")
    `HBRD_ASSERT_HOLDS(a_btns_bounded, aclk, aresetn, btn_total_reg <= 4'(MAX_BUTTONS),
        "button count above limit")
    `HBRD_ASSERT_HOLDS(a_axes_pairs, aclk, aresetn, axis_total_reg != 2'd1,
        "single valid axis recorded")
    `HBRD_ASSERT_NEXT(a_pop_fills_out, aclk, aresetn, pop, m_valid_reg,
        "executed beat not presented")

endmodule

// ===== rtl/core/hid_boot_report_decoder.sv =====
// An accepted beat is queued, then executed by the back end into the register behind m_tvalid.
// Throughput: one beat per cycle unless the queue is full; the two-entry queue between the
// classifier and the executing back end lets input flow for two beats while output stalls.
// Reset (aresetn low, synchronous): LEDs, key, button and axis state, byte position,
// device kind and the queue all clear; no clearing pass is needed afterwards.
module hid_boot_report_decoder #(
    parameter int MAX_KEYS    = hbrd_pkg::DEF_MAX_KEYS,
    parameter int MAX_BUTTONS = hbrd_pkg::DEF_MAX_BUTTONS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,     // device_kind
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // byte_value[7:0], item_index[10:8], zeros
    input  logic [2:0]  s_tuser,       // kind
    input  logic        s_tlast,       // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata        // read_value[8:0], led_state[16:9], keys_held[19:17],
                                       // buttons_held[23:20], axes_valid[25:24], zeros
);
    import hbrd_pkg::*;

    q_stat_t q_stat;
    op_t     push_op;
    op_t     pop_op;
    logic    push;
    logic    pop;

    hbrd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .push     (push),
        .push_op  (push_op)
    );

    hbrd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_op  (push_op),
        .pop      (pop),
        .pop_op   (pop_op),
        .q_stat   (q_stat)
    );

    hbrd_back #(
        .MAX_KEYS    (MAX_KEYS),
        .MAX_BUTTONS (MAX_BUTTONS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_stat    (q_stat),
        .pop_op    (pop_op),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
